/* sv/sor_pkg.sv */
// Shared types and constants for the sphere overlap resolver.
`timescale 1ns / 1ps
`default_nettype none
package sor_pkg;

	localparam int CoordW  = 32;
	localparam int RadW    = 31;
	localparam int RootW   = 32;                 // floor(sqrt) of a 64-bit sum
	localparam int RadiW   = 2 * RootW;          // radicand width
	localparam int SqRemW  = RootW + 2;          // sqrt partial remainder
	localparam int DivW    = RootW + 1;          // divisor 2*dist
	localparam int QuotW   = CoordW - 1;         // push is below 2^31
	localparam int NumW    = 2 * CoordW;         // mag * (R - dist)
	localparam int SqrtCells = RootW;
	localparam int DivCells  = QuotW;

	typedef logic signed [CoordW-1:0] coord_t;

	// words carried through the square root chain
	typedef struct packed {
		logic                         hit;
		logic                         move;
		logic [2:0]                   neg;
		logic [2:0][CoordW-1:0]       a;
		logic [2:0][CoordW-1:0]       b;
		logic [2:0][CoordW-1:0]       mag;
		logic [CoordW-1:0]            r;
	} sqp_t;

	// words carried through the divider chain
	typedef struct packed {
		logic                         hit;
		logic                         move;
		logic [2:0]                   neg;
		logic [2:0][CoordW-1:0]       a;
		logic [2:0][CoordW-1:0]       b;
		logic [DivW-1:0]              dv;
	} divp_t;

endpackage
`default_nettype wire

/* sv/sor_sqrt_cell.sv */
// One bit-pair step of the integer square root chain.
`timescale 1ns / 1ps
`default_nettype none
module sor_sqrt_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          v_i,
	input  wire logic [sor_pkg::RadiW-1:0]     rad_i,
	input  wire logic [sor_pkg::SqRemW-1:0]    rem_i,
	input  wire logic [sor_pkg::RootW-1:0]     root_i,
	input  wire sor_pkg::sqp_t                 pay_i,
	output logic                               v_q,
	output logic [sor_pkg::RadiW-1:0]          rad_q,
	output logic [sor_pkg::SqRemW-1:0]         rem_q,
	output logic [sor_pkg::RootW-1:0]          root_q,
	output sor_pkg::sqp_t                      pay_q
);

	logic [sor_pkg::SqRemW+1:0] rem_sh;
	logic [sor_pkg::SqRemW+1:0] trial;
	logic                       ge;
	logic [sor_pkg::SqRemW+1:0] rem_sub;

	// bring down the next pair, try root*4+1
	always_comb begin
		rem_sh  = {rem_i, rad_i[sor_pkg::RadiW-1 -: 2]};
		trial   = {2'b00, root_i, 2'b01};
		ge      = (rem_sh >= trial);
		rem_sub = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_i[sor_pkg::RadiW-3:0], 2'b00};
			rem_q  <= rem_sub[sor_pkg::SqRemW-1:0];
			root_q <= {root_i[sor_pkg::RootW-2:0], ge};
			pay_q  <= pay_i;
		end
	end

endmodule
`default_nettype wire

/* sv/sor_div_cell.sv */
// One restoring division step, three axes sharing one divisor.
`timescale 1ns / 1ps
`default_nettype none
module sor_div_cell (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  en,
	input  wire logic                                  v_i,
	input  wire logic [2:0][sor_pkg::DivW-1:0]         rem_i,
	input  wire logic [2:0][sor_pkg::QuotW-1:0]        num_i,
	input  wire logic [2:0][sor_pkg::QuotW-1:0]        quo_i,
	input  wire sor_pkg::divp_t                        pay_i,
	output logic                                       v_q,
	output logic [2:0][sor_pkg::DivW-1:0]              rem_q,
	output logic [2:0][sor_pkg::QuotW-1:0]             num_q,
	output logic [2:0][sor_pkg::QuotW-1:0]             quo_q,
	output sor_pkg::divp_t                             pay_q
);

	logic [2:0][sor_pkg::DivW:0]   rem_sh;
	logic [2:0][sor_pkg::DivW:0]   rem_sub;
	logic [2:0]                    ge;

	// shift in the next numerator bit, subtract when it fits
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rem_sh[k]  = {rem_i[k], num_i[k][sor_pkg::QuotW-1]};
			ge[k]      = (rem_sh[k] >= {1'b0, pay_i.dv});
			rem_sub[k] = ge[k] ? (rem_sh[k] - {1'b0, pay_i.dv}) : rem_sh[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				rem_q[k] <= rem_sub[k][sor_pkg::DivW-1:0];
				num_q[k] <= {num_i[k][sor_pkg::QuotW-2:0], 1'b0};
				quo_q[k] <= {quo_i[k][sor_pkg::QuotW-2:0], ge[k]};
			end
			pay_q <= pay_i;
		end
	end

endmodule
`default_nettype wire

/* sv/sphere_overlap_resolver.sv */
// Throughput: one word per cycle while no finished output word is held; the
// 32-cell root chain and the 31-cell divider chain each hold one word per cell
// and all stages advance together.
// A stalled output holds every stage; input stall follows output stall.
// Reset clears all stage valid bits; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module sphere_overlap_resolver (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [31:0]            a_x,
	input  wire logic signed [31:0]            a_y,
	input  wire logic signed [31:0]            a_z,
	input  wire logic [30:0]                   a_radius,
	input  wire logic signed [31:0]            b_x,
	input  wire logic signed [31:0]            b_y,
	input  wire logic signed [31:0]            b_z,
	input  wire logic [30:0]                   b_radius,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               hit,
	output logic signed [31:0]                 new_a_x,
	output logic signed [31:0]                 new_a_y,
	output logic signed [31:0]                 new_a_z,
	output logic signed [31:0]                 new_b_x,
	output logic signed [31:0]                 new_b_y,
	output logic signed [31:0]                 new_b_z
);

	localparam int CW = sor_pkg::CoordW;

	function automatic logic [CW-1:0] sat32(input logic signed [CW+1:0] v);
		logic [CW-1:0] r;
		if (v > $signed({3'b000, {(CW-1){1'b1}}})) begin
			r = {1'b0, {(CW-1){1'b1}}};
		end else if (v < $signed({3'b111, {(CW-1){1'b0}}})) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

	logic en;
	logic [2:0][CW-1:0] ain, bin;

	// whole pipe advances unless a finished word is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign ain = {a_z, a_y, a_x};
	assign bin = {b_z, b_y, b_x};

	// stage 1: differences, magnitudes, radius sum
	logic                 v_s1;
	sor_pkg::sqp_t        p_s1;
	logic [2:0][CW:0]     d_c;
	logic [2:0][CW:0]     m_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k] = {ain[k][CW-1], ain[k]} - {bin[k][CW-1], bin[k]};
			m_c[k] = d_c[k][CW] ? (~d_c[k] + 1'b1) : d_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1.hit  <= 1'b0;
			p_s1.move <= 1'b0;
			p_s1.a    <= ain;
			p_s1.b    <= bin;
			p_s1.r    <= {1'b0, a_radius} + {1'b0, b_radius};
			for (int k = 0; k < 3; k++) begin
				p_s1.neg[k] <= d_c[k][CW];
				p_s1.mag[k] <= m_c[k][CW-1:0];
			end
		end
	end

	// stage 2: squares
	logic                   v_s2;
	sor_pkg::sqp_t          p_s2;
	logic [2:0][2*CW-1:0]   sq_s2;
	logic [2*CW-1:0]        r2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2  <= p_s1;
			r2_s2 <= p_s1.r * p_s1.r;
			for (int k = 0; k < 3; k++) begin
				sq_s2[k] <= p_s1.mag[k] * p_s1.mag[k];
			end
		end
	end

	// stage 3: sum of squares, hit test
	logic                   v_s3;
	sor_pkg::sqp_t          p_s3;
	logic [2*CW-1:0]        s_s3;
	logic [2*CW+1:0]        sum_c;
	sor_pkg::sqp_t          p3_c;

	assign sum_c = {2'b00, sq_s2[0]} + {2'b00, sq_s2[1]} + {2'b00, sq_s2[2]};

	// coincident centres hit but do not move
	always_comb begin
		p3_c      = p_s2;
		p3_c.hit  = (sum_c <= {2'b00, r2_s2});
		p3_c.move = p3_c.hit && (sum_c != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= p3_c;
			s_s3 <= sum_c[2*CW-1:0];
		end
	end

	// square root chain
	logic          sv   [0:sor_pkg::SqrtCells];
	logic [sor_pkg::RadiW-1:0]  srad [0:sor_pkg::SqrtCells];
	logic [sor_pkg::SqRemW-1:0] srem [0:sor_pkg::SqrtCells];
	logic [sor_pkg::RootW-1:0]  sroot[0:sor_pkg::SqrtCells];
	sor_pkg::sqp_t              spay [0:sor_pkg::SqrtCells];

	assign sv[0]    = v_s3;
	assign srad[0]  = s_s3;
	assign srem[0]  = '0;
	assign sroot[0] = '0;
	assign spay[0]  = p_s3;

	for (genvar i = 0; i < sor_pkg::SqrtCells; i++) begin : g_sqrt
		sor_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (sv[i]),
			.rad_i  (srad[i]),
			.rem_i  (srem[i]),
			.root_i (sroot[i]),
			.pay_i  (spay[i]),
			.v_q    (sv[i+1]),
			.rad_q  (srad[i+1]),
			.rem_q  (srem[i+1]),
			.root_q (sroot[i+1]),
			.pay_q  (spay[i+1])
		);
	end

	// numerator stage: mag * (R - dist), divisor 2*dist
	logic                   v_n;
	sor_pkg::divp_t         p_n;
	logic [2:0][2*CW-1:0]   num_n;
	logic [CW-1:0]          diff_c;
	sor_pkg::sqp_t          sp_last;
	logic [sor_pkg::RootW-1:0] root_d;

	assign sp_last = spay[sor_pkg::SqrtCells];
	assign root_d  = sroot[sor_pkg::SqrtCells];
	assign diff_c  = sp_last.r - root_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_n <= 1'b0;
		end else if (en) begin
			v_n <= sv[sor_pkg::SqrtCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_n.hit  <= sp_last.hit;
			p_n.move <= sp_last.move;
			p_n.neg  <= sp_last.neg;
			p_n.a    <= sp_last.a;
			p_n.b    <= sp_last.b;
			p_n.dv   <= {root_d, 1'b0};
			for (int k = 0; k < 3; k++) begin
				num_n[k] <= sp_last.mag[k] * diff_c;
			end
		end
	end

	// divider chain
	logic dv_v [0:sor_pkg::DivCells];
	logic [2:0][sor_pkg::DivW-1:0]  drem [0:sor_pkg::DivCells];
	logic [2:0][sor_pkg::QuotW-1:0] dnum [0:sor_pkg::DivCells];
	logic [2:0][sor_pkg::QuotW-1:0] dquo [0:sor_pkg::DivCells];
	sor_pkg::divp_t                 dpay [0:sor_pkg::DivCells];

	assign dv_v[0] = v_n;
	assign dquo[0] = '0;
	assign dpay[0] = p_n;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			drem[0][k] = num_n[k][2*CW-1 -: sor_pkg::DivW];
			dnum[0][k] = num_n[k][sor_pkg::QuotW-1:0];
		end
	end

	for (genvar i = 0; i < sor_pkg::DivCells; i++) begin : g_div
		sor_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_i    (dv_v[i]),
			.rem_i  (drem[i]),
			.num_i  (dnum[i]),
			.quo_i  (dquo[i]),
			.pay_i  (dpay[i]),
			.v_q    (dv_v[i+1]),
			.rem_q  (drem[i+1]),
			.num_q  (dnum[i+1]),
			.quo_q  (dquo[i+1]),
			.pay_q  (dpay[i+1])
		);
	end

	// output stage: apply signed push, saturate
	sor_pkg::divp_t       dp_last;
	logic [2:0][CW-1:0]   na_c, nb_c;
	logic signed [CW+1:0] push_c;

	assign dp_last = dpay[sor_pkg::DivCells];

	always_comb begin
		push_c = '0;
		for (int k = 0; k < 3; k++) begin
			push_c = dp_last.neg[k]
				? -$signed({3'b000, dquo[sor_pkg::DivCells][k]})
				:  $signed({3'b000, dquo[sor_pkg::DivCells][k]});
			if (dp_last.move) begin
				na_c[k] = sat32($signed({{2{dp_last.a[k][CW-1]}}, dp_last.a[k]}) + push_c);
				nb_c[k] = sat32($signed({{2{dp_last.b[k][CW-1]}}, dp_last.b[k]}) - push_c);
			end else begin
				na_c[k] = dp_last.a[k];
				nb_c[k] = dp_last.b[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v[sor_pkg::DivCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit     <= dp_last.hit;
			new_a_x <= na_c[0];
			new_a_y <= na_c[1];
			new_a_z <= na_c[2];
			new_b_x <= nb_c[0];
			new_b_y <= nb_c[1];
			new_b_z <= nb_c[2];
		end
	end

endmodule
`default_nettype wire

/* sv/sor_checker.sv */
// Port-level checks for the sphere overlap resolver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sor_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               hit,
	input wire logic signed [31:0] new_a_x,
	input wire logic signed [31:0] new_b_x
);

	// held word stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// held word keeps its hit flag and its x coordinates
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hit) && $stable(new_a_x) && $stable(new_b_x))
		else $error("output word changed while stalled");

	// input stalls only when a finished word is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held output");

	// a held output always backs up the input
	a_stall_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input open while output held");

endmodule

bind sphere_overlap_resolver sor_checker u_sor_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.new_a_x   (new_a_x),
	.new_b_x   (new_b_x)
);
`default_nettype wire

/* tb/sv/sphere_overlap_resolver_tb.sv */
// Self-checking testbench for the sphere overlap resolver.
`timescale 1ns / 1ps

module sphere_overlap_resolver_tb;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [30:0]      a_rad;
		logic [2:0][31:0] b;
		logic [30:0]      b_rad;
	} sphere_pair_t;

	typedef struct packed {
		logic             hit;
		logic [2:0][31:0] na;
		logic [2:0][31:0] nb;
	} resolved_t;

	// expected resolutions in order, and the resolution predictor
	class overlap_scoreboard;
		resolved_t pending_q[$];
		int        errors = 0;

		function logic [31:0] clamp32(logic signed [71:0] v);
			if (v > 72'sh7FFFFFFF)
				return 32'h7FFFFFFF;
			if (v < -72'sh80000000)
				return 32'h80000000;
			return v[31:0];
		endfunction

		function resolved_t resolve_pair(sphere_pair_t p);
			logic signed [71:0] av [3];
			logic signed [71:0] bv [3];
			logic signed [71:0] dv [3];
			logic signed [71:0] shift;
			logic [71:0]        mag [3];
			logic [71:0]        sum_sq, rsum, root, trial, push;
			resolved_t          o;
			sum_sq = 0;
			for (int k = 0; k < 3; k++) begin
				av[k]  = $signed(p.a[k]);
				bv[k]  = $signed(p.b[k]);
				dv[k]  = av[k] - bv[k];
				mag[k] = dv[k] < 0 ? -dv[k] : dv[k];
				sum_sq += mag[k] * mag[k];
			end
			rsum  = 72'(p.a_rad) + 72'(p.b_rad);
			o.hit = sum_sq <= rsum * rsum;
			// coincident centres: hit, nothing moves
			if (o.hit && sum_sq != 0) begin
				root = 0;
				for (int i = 35; i >= 0; i--) begin
					trial = root | (72'd1 << i);
					if (trial * trial <= sum_sq)
						root = trial;
				end
				for (int k = 0; k < 3; k++) begin
					push = (mag[k] * (rsum - root)) / (2 * root);
					if (push > 72'h400000000)
						push = 72'h400000000;
					shift = dv[k] < 0 ? -$signed(push) : $signed(push);
					av[k] += shift;
					bv[k] -= shift;
				end
			end
			for (int k = 0; k < 3; k++) begin
				o.na[k] = clamp32(av[k]);
				o.nb[k] = clamp32(bv[k]);
			end
			return o;
		endfunction

		function void note_pair(sphere_pair_t p);
			pending_q.push_back(resolve_pair(p));
		endfunction

		function void check_result(resolved_t got);
			resolved_t want;
			string     ax;
			if (pending_q.size() == 0) begin
				$error("result word with no pair outstanding");
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, got %0d", want.hit, got.hit);
				errors++;
			end
			for (int k = 0; k < 3; k++) begin
				ax = k == 0 ? "x" : (k == 1 ? "y" : "z");
				if (got.na[k] !== want.na[k]) begin
					$error("new_a_%s: expected %h, got %h", ax, want.na[k], got.na[k]);
					errors++;
				end
				if (got.nb[k] !== want.nb[k]) begin
					$error("new_b_%s: expected %h, got %h", ax, want.nb[k], got.nb[k]);
					errors++;
				end
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [31:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0;
	logic [30:0]        a_radius = 0, b_radius = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic               hit;
	logic signed [31:0] new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z;

	overlap_scoreboard sb = new();
	int  accepted = 0;
	int  cycles = 0;
	bit  quiet = 0;        // no idling on either side
	bit  hold_out = 0;     // receiver holds off for a long stretch

	sphere_overlap_resolver DUT (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("sphere_overlap_resolver_tb: FAIL");
			$finish;
		end
	end

	// sample both handshakes
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			sb.note_pair({a_z, a_y, a_x, a_radius, b_z, b_y, b_x, b_radius});
			accepted++;
		end
		if (arst_n && out_valid && !out_stall)
			sb.check_result({hit, new_a_z, new_a_y, new_a_x, new_b_z, new_b_y, new_b_x});
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_stall = 1;
				for (n = 0; n < 300; n++)
					@(negedge clk);
				hold_out = 0;
				out_stall = 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall = 1;
				n = $urandom_range(1, 14);
				repeat (n - 1) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	// offer one word and wait for it to be taken
	task automatic send_pair(sphere_pair_t p);
		int target;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		{a_z, a_y, a_x, a_radius, b_z, b_y, b_x, b_radius} = p;
		in_valid = 1;
		target = accepted + 1;
		do @(negedge clk); while (accepted < target);
	endtask

	task automatic send_raw(logic [31:0] ax, ay, az, logic [30:0] ar,
			logic [31:0] bx, by, bz, logic [30:0] br);
		sphere_pair_t p;
		p.a = {az, ay, ax};
		p.b = {bz, by, bx};
		p.a_rad = ar;
		p.b_rad = br;
		send_pair(p);
	endtask

	// random pair: mostly close pairs at a random scale, some fully random
	function automatic sphere_pair_t random_pair();
		sphere_pair_t p;
		int           sh;
		logic [31:0]  m;
		for (int k = 0; k < 3; k++)
			p.a[k] = $urandom;
		p.a_rad = $urandom;
		p.b_rad = $urandom;
		if ($urandom_range(0, 4) == 0) begin
			for (int k = 0; k < 3; k++)
				p.b[k] = $urandom;
		end else begin
			sh = $urandom_range(2, 30);
			m  = (32'd1 << sh) - 1;
			for (int k = 0; k < 3; k++)
				p.b[k] = p.a[k] + ($signed($urandom & m) - $signed(m >> 1));
			p.a_rad = $urandom & m;
			p.b_rad = $urandom & m;
			if ($urandom_range(0, 9) == 0)
				p.b = p.a;
		end
		return p;
	endfunction

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: extremes, coincident, touching, no hit, saturation
		send_raw(0, 0, 0, 0, 0, 0, 0, 0);
		send_raw(32'h7FFFFFFF, 32'h80000000, 5, 31'h7FFFFFFF,
			32'h7FFFFFFF, 32'h80000000, 5, 31'h7FFFFFFF);
		send_raw(32'h80000000, 32'h80000000, 32'h80000000, 0,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
		send_raw(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_raw(32'h00030000, 0, 0, 31'h00010000, 0, 0, 0, 31'h00020000);
		send_raw(32'h00030001, 0, 0, 31'h00010000, 0, 0, 0, 31'h00020000);
		send_raw(0, 32'h00010000, 0, 31'h00010000, 0, 0, 0, 31'h00010000);
		send_raw(0, 0, 32'hFFFF0000, 31'h00010000, 0, 0, 0, 31'h00010000);
		send_raw(32'h7FFFFFF0, 0, 0, 31'h40000000,
			32'h7FFFFFE0, 0, 0, 31'h40000000);
		send_raw(32'h80000010, 32'h80000010, 0, 31'h40000000,
			32'h80000020, 32'h80000020, 0, 31'h40000000);
		send_raw(1, 2, 3, 31'h7FFFFFFF, 0, 0, 0, 31'h7FFFFFFF);
		send_raw(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 31'h55555555,
			32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 31'h2AAAAAAA);
		send_raw(32'h00001000, 32'hFFFFF000, 32'h00000800, 31'h1000,
			32'hFFFFF000, 32'h00001000, 32'hFFFFF800, 31'h1000);

		// random, with a long output hold-off early on, a full drain midway and a quiet tail
		for (int i = 0; i < 1530; i++) begin
			if (i == 100)
				hold_out = 1;
			if (i == 700) begin
				in_valid = 0;
				wait (sb.pending_q.size() == 0);
				@(negedge clk);
			end
			if (i == 1300)
				quiet = 1;
			send_pair(random_pair());
		end
		in_valid = 0;

		wait (sb.pending_q.size() == 0);
		repeat (80) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("sphere_overlap_resolver_tb: PASS");
		else
			$display("sphere_overlap_resolver_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
sv/sor_pkg.sv
sv/sor_sqrt_cell.sv
sv/sor_div_cell.sv
sv/sphere_overlap_resolver.sv
sv/sor_checker.sv
tb/sv/sphere_overlap_resolver_tb.sv
